// File: rtl/dq_pkg.sv
// Shared action and status codes for the double-ended queue core.
// No dependencies; imported by the entry store and the queue top level.
package dq_pkg;

    typedef logic [2:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_BACK  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_BACK   = 3'd3;
    localparam action_t ACT_QUERY      = 3'd4;

    localparam status_t STS_OK         = 2'd0;
    localparam status_t STS_FULL_DROP  = 2'd1;
    localparam status_t STS_EMPTY_POP  = 2'd2;

    localparam int VALUE_W = 32;

endpackage

// File: rtl/dq_ram.sv
// Entry store for the double-ended queue: one write port, one read port,
// read data registered. Uses dq_pkg for the value width.
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit values held in a ring memory.
// Depends on dq_pkg (codes, types) and dq_ram (entry store).
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction: action and
//   item_value. Actions: push front, push back, pop front, pop back, query;
//   unused codes behave as a query.
//   Output channel (out_valid/out_stall) returns one transaction per input:
//   front and back values (zero when empty), has_items, item_count, status.
//   Pushes, queries and pops that leave no entry behind show their result
//   the cycle after the input transaction; a pop that leaves entries behind
//   first passes the read state, where the registered read of the entry
//   store fetches the new front or back value. Throughput: one transaction
//   every cycle unless out_stall holds a result; such pops stall the input.
//   Front and back values are cached in registers; the memory is written
//   on every push that stores an entry and read only on a pop that leaves entries behind.
//   Reset clears the pointers and the count; the store itself is not
//   cleared, and the block accepts transactions right after reset.
//   While the receiver stalls a pending result, the result holds and
//   in_stall stays high until the result is taken.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   action,
    input  logic signed [VALUE_W-1:0]    item_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_W-1:0]    front_value,
    output logic signed [VALUE_W-1:0]    back_value,
    output logic                         has_items,
    output logic [$clog2(DEPTH + 1)-1:0] item_count,
    output logic [1:0]                   status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic pop_front_reg, pop_front_next;
    logic signed [VALUE_W-1:0] front_val_reg, front_val_next;
    logic signed [VALUE_W-1:0] back_val_reg, back_val_next;

    logic out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_front_reg, out_front_next;
    logic signed [VALUE_W-1:0] out_back_reg, out_back_next;
    logic out_has_reg, out_has_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    status_t out_status_reg, out_status_next;

    logic in_accept;
    logic wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
    logic is_empty, is_full;
    status_t sts;

    dq_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        count_next      = count_reg;
        pop_front_next  = pop_front_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        rd_en           = 1'b0;
        rd_addr         = front_inc;
        sts             = STS_OK;

        out_valid_next  = out_valid_reg && out_stall;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_has_next    = out_has_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;

        if (state_reg == ST_READ)
        begin
            if (pop_front_reg)
            begin
                front_val_next = rd_data;
            end
            else
            begin
                back_val_next = rd_data;
            end
            out_valid_next  = 1'b1;
            out_front_next  = pop_front_reg ? rd_data : front_val_reg;
            out_back_next   = pop_front_reg ? back_val_reg : rd_data;
            out_has_next    = 1'b1;
            out_count_next  = count_reg;
            out_status_next = STS_OK;
            state_next      = ST_IDLE;
        end
        else if (in_accept)
        begin
            unique case (action)
                ACT_PUSH_FRONT, ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        sts = STS_FULL_DROP;
                    end
                    else if (is_empty)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = front_reg;
                        back_next      = front_reg;
                        front_val_next = item_value;
                        back_val_next  = item_value;
                        count_next     = CNT_W'(1);
                    end
                    else if (action == ACT_PUSH_FRONT)
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = front_dec;
                        front_next     = front_dec;
                        front_val_next = item_value;
                        count_next     = count_reg + 1'b1;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = back_inc;
                        back_next     = back_inc;
                        back_val_next = item_value;
                        count_next    = count_reg + 1'b1;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        sts = STS_EMPTY_POP;
                    end
                    else if (count_reg == CNT_W'(1))
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        count_next     = count_reg - 1'b1;
                        pop_front_next = (action == ACT_POP_FRONT);
                        state_next     = ST_READ;
                        if (action == ACT_POP_FRONT)
                        begin
                            front_next = front_inc;
                            rd_addr    = front_inc;
                        end
                        else
                        begin
                            back_next = back_dec;
                            rd_addr   = back_dec;
                        end
                    end
                end
                default:
                begin
                    sts = STS_OK;
                end
            endcase

            if (state_next == ST_IDLE)
            begin
                out_valid_next  = 1'b1;
                out_has_next    = (count_next != '0);
                out_front_next  = (count_next != '0) ? front_val_next : '0;
                out_back_next   = (count_next != '0) ? back_val_next : '0;
                out_count_next  = count_next;
                out_status_next = sts;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            pop_front_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            pop_front_reg <= pop_front_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg  <= front_val_next;
        back_val_reg   <= back_val_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_has_reg    <= out_has_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign has_items   = out_has_reg;
    assign item_count  = out_count_reg;
    assign status      = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds depth");

    a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> in_stall)
        else $error("input taken while a pop read is pending");

    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("pop read did not produce a result");

    a_has_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_has_reg == (out_count_reg != '0)))
        else $error("has_items disagrees with item_count");

endmodule
